/* rtl/core/two_channel_smoothing_filter_core_assert.svh */
// Assertion macros shared by the smoothing filter RTL.
// Both macros sample on the rising edge of aclk and are disabled during reset.
`ifndef TWO_CHANNEL_SMOOTHING_FILTER_CORE_ASSERT_SVH
`define TWO_CHANNEL_SMOOTHING_FILTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCSF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TCSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/tcsf_pkg.sv */
`timescale 1ns / 1ps

package tcsf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FACTOR_W = 8;
    localparam int DIV_W    = FACTOR_W + 1;
    localparam int REM_W    = DIV_W - 1;
    localparam int NUM_W    = SAMPLE_W + FACTOR_W + 1;
    localparam int MAG_W    = NUM_W - 1;
    localparam int QUO_W    = SAMPLE_W;
    localparam int MUL_CNT_W = $clog2(FACTOR_W);
    localparam int DIV_CNT_W = $clog2(QUO_W);
    localparam int CFG_ADDR_W = 2;

    localparam logic [SAMPLE_W-1:0] NO_CONVERSION = '1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PH_FACTOR  = 2'd0,
        REG_PH_ENABLE  = 2'd1,
        REG_ORP_FACTOR = 2'd2,
        REG_ORP_ENABLE = 2'd3
    } cfg_reg_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [NUM_W-1:0]    num_t;

endpackage

/* rtl/core/tcsf_ser_mul.sv */
`timescale 1ns / 1ps

module tcsf_ser_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [tcsf_pkg::FACTOR_W-1:0]      factor,
    input  tcsf_pkg::sample_t                  multiplicand,
    input  tcsf_pkg::sample_t                  addend,
    output logic                               done,
    output tcsf_pkg::num_t                     product
);

    // Shift-add multiplier: one factor bit per cycle, accumulator preloaded with the addend.
    tcsf_pkg::num_t                        acc_reg, acc_next;
    tcsf_pkg::num_t                        mcand_reg, mcand_next;
    logic [tcsf_pkg::FACTOR_W-1:0]         mplier_reg, mplier_next;
    logic [tcsf_pkg::MUL_CNT_W-1:0]        cnt_reg, cnt_next;
    logic                                  busy_reg, busy_next;
    logic                                  done_reg, done_next;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start) begin
            acc_next    = tcsf_pkg::num_t'(addend);
            mcand_next  = tcsf_pkg::num_t'(multiplicand);
            mplier_next = factor;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == tcsf_pkg::MUL_CNT_W'(tcsf_pkg::FACTOR_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* rtl/core/tcsf_ser_div.sv */
`timescale 1ns / 1ps

module tcsf_ser_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  tcsf_pkg::num_t                 dividend,
    input  logic [tcsf_pkg::DIV_W-1:0]     divisor,
    output logic                           done,
    output tcsf_pkg::sample_t              quotient
);

    // Restoring division of the magnitude, one quotient bit per cycle. The quotient is known
    // to fit in the sample width, so the upper dividend bits already form the first remainder.
    logic [tcsf_pkg::NUM_W-1:0]        neg_num;
    logic [tcsf_pkg::MAG_W-1:0]        mag;
    logic [tcsf_pkg::DIV_W-1:0]        partial;
    logic [tcsf_pkg::DIV_W:0]          diff;
    logic [tcsf_pkg::REM_W-1:0]        rem_reg, rem_next;
    logic [tcsf_pkg::QUO_W-1:0]        q_reg, q_next;
    logic [tcsf_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                              sign_reg, sign_next;
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;

    assign neg_num = -dividend;
    assign mag     = dividend[tcsf_pkg::NUM_W-1] ? neg_num[tcsf_pkg::MAG_W-1:0]
                                                 : dividend[tcsf_pkg::MAG_W-1:0];
    assign partial = {rem_reg, q_reg[tcsf_pkg::QUO_W-1]};
    assign diff    = {1'b0, partial} - {1'b0, divisor};

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        sign_next = sign_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = mag[tcsf_pkg::MAG_W-1:tcsf_pkg::QUO_W];
            q_next    = mag[tcsf_pkg::QUO_W-1:0];
            sign_next = dividend[tcsf_pkg::NUM_W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (diff[tcsf_pkg::DIV_W]) begin
                rem_next = partial[tcsf_pkg::REM_W-1:0];
            end else begin
                rem_next = diff[tcsf_pkg::REM_W-1:0];
            end
            q_next   = {q_reg[tcsf_pkg::QUO_W-2:0], ~diff[tcsf_pkg::DIV_W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tcsf_pkg::DIV_CNT_W'(tcsf_pkg::QUO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        sign_reg <= sign_next;
    end

    assign done     = done_reg;
    assign quotient = sign_reg ? tcsf_pkg::sample_t'(~q_reg + 1'b1) : tcsf_pkg::sample_t'(q_reg);

endmodule

/* rtl/core/two_channel_smoothing_filter_core.sv */
// An updating sample passes from its input transfer through the bit-serial multiplier,
// the bit-serial divider, a store of the new value and the output register load.
// One item is in flight at a time, so a new sample is accepted only once the last result is loaded.
// An ignored sample skips the multiplier and divider and goes straight to the output load.
// A stalled result transfer holds the input until it completes. Synchronous active-low reset
// clears both stored values to zero and sets factors to 5 with both channels disabled.
`timescale 1ns / 1ps

`include "two_channel_smoothing_filter_core_assert.svh"

module two_channel_smoothing_filter_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [15:0]                            s_tdata,  // [15:0] sample
    input  logic                                   s_tuser,  // [0] channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [31:0]                            m_tdata,  // [15:0] filtered_ph, [31:16] filtered_orp
    output logic                                   m_tuser,  // [0] updated
    input  logic                                   cfg_wr_en,
    input  logic [tcsf_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [tcsf_pkg::FACTOR_W-1:0]          cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                            state_reg, state_next;
    logic [tcsf_pkg::FACTOR_W-1:0]     ph_factor_reg, orp_factor_reg;
    logic                              ph_enable_reg, orp_enable_reg;
    tcsf_pkg::sample_t                 ph_val_reg, ph_val_next;
    tcsf_pkg::sample_t                 orp_val_reg, orp_val_next;
    logic                              chan_reg, chan_next;
    logic                              upd_reg, upd_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [31:0]                       m_tdata_reg, m_tdata_next;
    logic                              m_tuser_reg, m_tuser_next;

    logic                              s_xfer;
    logic                              in_enable;
    logic [tcsf_pkg::FACTOR_W-1:0]     in_factor;
    logic                              take_sample;
    logic                              out_free;
    tcsf_pkg::sample_t                 old_val;
    logic [tcsf_pkg::DIV_W-1:0]        divisor;
    logic                              mul_done;
    tcsf_pkg::num_t                    product;
    logic                              div_start;
    logic                              div_done;
    tcsf_pkg::sample_t                 quotient;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_xfer      = s_tvalid && s_tready;
    assign in_enable   = s_tuser ? orp_enable_reg : ph_enable_reg;
    assign in_factor   = s_tuser ? orp_factor_reg : ph_factor_reg;
    assign take_sample = in_enable && (s_tdata != tcsf_pkg::NO_CONVERSION);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign old_val     = s_tuser ? orp_val_reg : ph_val_reg;
    assign divisor     = {1'b0, chan_reg ? orp_factor_reg : ph_factor_reg} + 1'b1;
    assign div_start   = (state_reg == ST_MUL) && mul_done;

    tcsf_ser_mul u_mul (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (s_xfer && take_sample),
        .factor       (in_factor),
        .multiplicand (old_val),
        .addend       (tcsf_pkg::sample_t'(s_tdata)),
        .done         (mul_done),
        .product      (product)
    );

    tcsf_ser_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        state_next    = state_reg;
        ph_val_next   = ph_val_reg;
        orp_val_next  = orp_val_reg;
        chan_next     = chan_reg;
        upd_next      = upd_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    chan_next  = s_tuser;
                    upd_next   = take_sample;
                    state_next = take_sample ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (chan_reg) begin
                        orp_val_next = quotient;
                    end else begin
                        ph_val_next = quotient;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {orp_val_reg, ph_val_reg};
                    m_tuser_next  = upd_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            ph_val_reg     <= '0;
            orp_val_reg    <= '0;
            ph_factor_reg  <= tcsf_pkg::FACTOR_W'(5);
            orp_factor_reg <= tcsf_pkg::FACTOR_W'(5);
            ph_enable_reg  <= 1'b0;
            orp_enable_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            ph_val_reg   <= ph_val_next;
            orp_val_reg  <= orp_val_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    tcsf_pkg::REG_PH_FACTOR:  ph_factor_reg  <= cfg_wdata;
                    tcsf_pkg::REG_PH_ENABLE:  ph_enable_reg  <= cfg_wdata[0];
                    tcsf_pkg::REG_ORP_FACTOR: orp_factor_reg <= cfg_wdata;
                    tcsf_pkg::REG_ORP_ENABLE: orp_enable_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
        chan_reg    <= chan_next;
        upd_reg     <= upd_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `TCSF_ASSERT_SAME(a_mul_done_in_mul, mul_done, state_reg == ST_MUL)
    `TCSF_ASSERT_SAME(a_div_done_in_div, div_done, state_reg == ST_DIV)
    `TCSF_ASSERT_NEXT(a_skip_to_done, s_xfer && !take_sample, state_reg == ST_DONE)

endmodule
